@@ src/omk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package omk_pkg;

  // CORDIC datapath widths: x and y carry Q30 values with headroom, z is a
  // 32-bit binary angle residue.
  localparam int CordicSteps = 30;
  localparam int XyW = 33;
  localparam int ZW = 32;
  localparam int CsW = 17;

  typedef logic signed [CsW-1:0] cs_t;

  localparam logic signed [XyW-1:0] CORDIC_X0 = 33'sd652032874;

  localparam logic [31:0] CORDIC_ATAN [CordicSteps] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  localparam logic [2:0] REG_ANGLE_A   = 3'd0;
  localparam logic [2:0] REG_ANGLE_B   = 3'd1;
  localparam logic [2:0] REG_ANGLE_C   = 3'd2;
  localparam logic [2:0] REG_ANGLE_D   = 3'd3;
  localparam logic [2:0] REG_BODY_DIST = 3'd4;
  localparam logic [2:0] REG_RADIUS    = 3'd5;
  localparam logic [2:0] REG_MAX_SPEED = 3'd6;

endpackage
`default_nettype wire

@@ src/omk_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module omk_cordic #(
  parameter int LANES = 5,
  parameter int SW = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire logic [LANES-1:0][31:0] theta,
  input  wire logic [SW-1:0]         in_side,
  output logic                       out_valid,
  output omk_pkg::cs_t               cos_q [LANES],
  output omk_pkg::cs_t               sin_q [LANES],
  output logic [SW-1:0]              out_side
);

  localparam int Steps = omk_pkg::CordicSteps;
  localparam int XW = omk_pkg::XyW;
  localparam int ZW = omk_pkg::ZW;

  logic signed [XW-1:0] xr [Steps][LANES];
  logic signed [XW-1:0] yr [Steps][LANES];
  logic signed [ZW-1:0] zr [Steps][LANES];
  logic [1:0]           quad [Steps][LANES];
  logic                 vld [Steps];
  logic [SW-1:0]        side [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [XW-1:0] xi;
      logic signed [XW-1:0] yi;
      logic signed [ZW-1:0] zi;
      logic [1:0]           qi;
      if (s == 0) begin : g_first
        assign xi = omk_pkg::CORDIC_X0;
        assign yi = '0;
        assign zi = $signed({2'b00, theta[l][29:0]});
        assign qi = theta[l][31:30];
      end else begin : g_next
        assign xi = xr[s-1][l];
        assign yi = yr[s-1][l];
        assign zi = zr[s-1][l];
        assign qi = quad[s-1][l];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zi[ZW-1]) begin
            xr[s][l] <= xi - (yi >>> s);
            yr[s][l] <= yi + (xi >>> s);
            zr[s][l] <= zi - $signed(omk_pkg::CORDIC_ATAN[s]);
          end else begin
            xr[s][l] <= xi + (yi >>> s);
            yr[s][l] <= yi - (xi >>> s);
            zr[s][l] <= zi + $signed(omk_pkg::CORDIC_ATAN[s]);
          end
          quad[s][l] <= qi;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[s] <= (s == 0) ? in_side : side[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Rounds a Q30 value half away from zero to Q15.
  function automatic omk_pkg::cs_t q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] m;
    logic signed [XW-1:0] t;
    m = v[XW-1] ? -v : v;
    t = (m + XW'(16384)) >>> 15;
    return omk_pkg::cs_t'(v[XW-1] ? -t : t);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[Steps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= side[Steps-1];
      for (int l = 0; l < LANES; l++) begin
        case (quad[Steps-1][l])
          2'd0: begin
            cos_q[l] <= q15(xr[Steps-1][l]);
            sin_q[l] <= q15(yr[Steps-1][l]);
          end
          2'd1: begin
            cos_q[l] <= -q15(yr[Steps-1][l]);
            sin_q[l] <= q15(xr[Steps-1][l]);
          end
          2'd2: begin
            cos_q[l] <= -q15(xr[Steps-1][l]);
            sin_q[l] <= -q15(yr[Steps-1][l]);
          end
          default: begin
            cos_q[l] <= q15(yr[Steps-1][l]);
            sin_q[l] <= -q15(xr[Steps-1][l]);
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ src/omk_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module omk_div #(
  parameter int LANES = 4,
  parameter int DW = 32,
  parameter int VW = 12,
  parameter int QW = 32,
  parameter int SW = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic [LANES-1:0][DW-1:0] dividend,
  input  wire logic [VW-1:0]          divisor,
  input  wire logic [SW-1:0]          in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quotient,
  output logic [SW-1:0]               out_side
);

  // One quotient bit per stage, most significant first. The caller makes
  // sure the quotient fits in QW bits.
  localparam int RW = ((DW > VW + QW) ? DW : VW + QW) + 1;

  logic [RW-1:0] rem [QW][LANES];
  logic [QW-1:0] quo [QW][LANES];
  logic [VW-1:0] dv [QW];
  logic [SW-1:0] side [QW];
  logic          vld [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [VW-1:0] dvi;
    if (k == 0) begin : g_first
      assign dvi = divisor;
    end else begin : g_next
      assign dvi = dv[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] ri;
      logic [QW-1:0] qi;
      logic [RW-1:0] sub;
      if (k == 0) begin : g_first
        assign ri = RW'(dividend[l]);
        assign qi = '0;
      end else begin : g_next
        assign ri = rem[k-1][l];
        assign qi = quo[k-1][l];
      end
      assign sub = RW'(dvi) << B;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (ri >= sub) begin
            rem[k][l] <= ri - sub;
            quo[k][l] <= qi | (QW'(1) << B);
          end else begin
            rem[k][l] <= ri;
            quo[k][l] <= qi;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k]   <= dvi;
        side[k] <= (k == 0) ? in_side : side[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_side  = side[QW-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quotient[l] = quo[QW-1][l];
  end

endmodule
`default_nettype wire

@@ src/omni_wheel_speed_kinematics.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Latency: 88 register stages lie between an input transfer and the output port.
// Throughput: one command per cycle; the whole pipeline advances together and
// holds while a finished result waits under out_stall.
// Reset: the valid bits of every stage clear and the configuration registers
// take their default values; no clearing pass is needed.
module omni_wheel_speed_kinematics #(
  parameter int WHEEL_COUNT = 4,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] speed_x,
  input  wire logic signed [15:0] speed_y,
  input  wire logic signed [15:0] spin_rate,
  input  wire logic [15:0]        heading,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      wheel_speed_a,
  output logic signed [15:0]      wheel_speed_b,
  output logic signed [15:0]      wheel_speed_c,
  output logic signed [15:0]      wheel_speed_d,
  output logic                    was_limited,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int WC = WHEEL_COUNT;
  localparam int LANES = WHEEL_COUNT + 1;
  localparam int AngShift = 32 - ANGLE_BITS;
  localparam int NumW = 56;
  localparam int Side2W = 1 + WC + WC * 32;

  // Configuration registers.
  logic [3:0][15:0] wheel_angle;
  logic [11:0]      body_wheel_distance;
  logic [11:0]      wheel_radius;
  logic [14:0]      max_wheel_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_angle[0]      <= 16'd6007;
      wheel_angle[1]      <= 16'd26760;
      wheel_angle[2]      <= 16'd40960;
      wheel_angle[3]      <= 16'd57344;
      body_wheel_distance <= 12'd806;
      wheel_radius        <= 12'd276;
      max_wheel_speed     <= 15'd28160;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        omk_pkg::REG_ANGLE_A:   wheel_angle[0] <= cfg_data;
        omk_pkg::REG_ANGLE_B:   wheel_angle[1] <= cfg_data;
        omk_pkg::REG_ANGLE_C:   wheel_angle[2] <= cfg_data;
        omk_pkg::REG_ANGLE_D:   wheel_angle[3] <= cfg_data;
        omk_pkg::REG_BODY_DIST: body_wheel_distance <= cfg_data[11:0];
        omk_pkg::REG_RADIUS:    wheel_radius <= cfg_data[11:0];
        omk_pkg::REG_MAX_SPEED: max_wheel_speed <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Global pipeline advance: everything moves unless a result is held.
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Binary angles scaled to a full 32-bit turn.
  function automatic logic [31:0] turn32(input logic [15:0] a);
    logic [47:0] ext;
    ext = {32'b0, a} << AngShift;
    return ext[31:0];
  endfunction

  logic [LANES-1:0][31:0] theta;
  always_comb begin
    theta[0] = turn32(heading);
    for (int l = 0; l < WC; l++) begin
      theta[l+1] = turn32(wheel_angle[l]);
    end
  end

  logic         c_valid;
  omk_pkg::cs_t cos_q [LANES];
  omk_pkg::cs_t sin_q [LANES];
  logic [47:0]  c_side;

  omk_cordic #(
    .LANES(LANES),
    .SW(48)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(in_valid),
    .theta(theta),
    .in_side({speed_x, speed_y, spin_rate}),
    .out_valid(c_valid),
    .cos_q(cos_q),
    .sin_q(sin_q),
    .out_side(c_side)
  );

  // Heading rotation products.
  logic                r1_valid;
  logic signed [32:0]  p_xc, p_ys, p_xs, p_yc;
  omk_pkg::cs_t        r1_ca [WC];
  omk_pkg::cs_t        r1_sa [WC];
  logic signed [15:0]  r1_spin;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (adv) begin
      r1_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xc    <= $signed(c_side[47:32]) * cos_q[0];
      p_ys    <= $signed(c_side[31:16]) * sin_q[0];
      p_xs    <= $signed(c_side[47:32]) * sin_q[0];
      p_yc    <= $signed(c_side[31:16]) * cos_q[0];
      r1_spin <= $signed(c_side[15:0]);
      for (int l = 0; l < WC; l++) begin
        r1_ca[l] <= cos_q[l+1];
        r1_sa[l] <= sin_q[l+1];
      end
    end
  end

  // Robot-frame velocity, Q15 mm/s.
  logic               r2_valid;
  logic signed [33:0] vxr, vyr;
  omk_pkg::cs_t       r2_ca [WC];
  omk_pkg::cs_t       r2_sa [WC];
  logic signed [15:0] r2_spin;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (adv) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vxr     <= 34'(p_xc) + 34'(p_ys);
      vyr     <= 34'(p_yc) - 34'(p_xs);
      r2_spin <= r1_spin;
      r2_ca   <= r1_ca;
      r2_sa   <= r1_sa;
    end
  end

  // Per-wheel products.
  logic               r3_valid;
  logic signed [50:0] m_s [WC];
  logic signed [50:0] m_c [WC];
  logic signed [28:0] spin_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (adv) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spin_term <= r2_spin * $signed({1'b0, body_wheel_distance});
      for (int l = 0; l < WC; l++) begin
        m_s[l] <= r2_sa[l] * vxr;
        m_c[l] <= r2_ca[l] * vyr;
      end
    end
  end

  // Wheel numerator in Q30 units of 0.1 mm/s.
  logic                  r4_valid;
  logic signed [NumW-1:0] num [WC];
  logic signed [NumW-1:0] num_c [WC];

  always_comb begin
    logic signed [NumW-1:0] d;
    logic signed [NumW-1:0] st;
    st = NumW'(spin_term);
    for (int l = 0; l < WC; l++) begin
      d = NumW'(m_c[l]) - NumW'(m_s[l]);
      num_c[l] = (d <<< 3) + (d <<< 1) + (st <<< 18);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r4_valid <= 1'b0;
    end else if (adv) begin
      r4_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num <= num_c;
    end
  end

  // Magnitude with the rounding half of the divisor added, and the
  // 2^22 part of the divisor taken off by a shift.
  logic [11:0] radius_eff;
  assign radius_eff = (wheel_radius == 12'd0) ? 12'd1 : wheel_radius;

  logic                   r5_valid;
  logic [WC-1:0][31:0]    r5_q;
  logic [WC-1:0]          r5_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r5_valid <= 1'b0;
    end else if (adv) begin
      r5_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [NumW-1:0] mag;
    if (adv) begin
      for (int l = 0; l < WC; l++) begin
        mag = (num[l][NumW-1] ? NumW'(-num[l]) : NumW'(num[l])) +
              (NumW'(radius_eff) << 21);
        r5_q[l]   <= mag[53:22];
        r5_neg[l] <= num[l][NumW-1];
      end
    end
  end

  logic                d1_valid;
  logic [WC-1:0][31:0] d1_q;
  logic [WC-1:0]       d1_neg;

  omk_div #(
    .LANES(WC),
    .DW(32),
    .VW(12),
    .QW(32),
    .SW(WC)
  ) u_div_radius (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(r5_valid),
    .dividend(r5_q),
    .divisor(radius_eff),
    .in_side(r5_neg),
    .out_valid(d1_valid),
    .quotient(d1_q),
    .out_side(d1_neg)
  );

  // Largest wheel magnitude.
  logic                l1_valid;
  logic [WC-1:0][31:0] l1_mag;
  logic [WC-1:0]       l1_neg;
  logic [31:0]         l1_big;
  logic [31:0]         big_c;

  always_comb begin
    big_c = '0;
    for (int l = 0; l < WC; l++) begin
      if (d1_q[l] > big_c) begin
        big_c = d1_q[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else if (adv) begin
      l1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_mag <= d1_q;
      l1_neg <= d1_neg;
      l1_big <= big_c;
    end
  end

  // Limit check and scale products.
  logic                l2_valid;
  logic                l2_lim;
  logic [WC-1:0][46:0] l2_prod;
  logic [WC-1:0][31:0] l2_mag;
  logic [WC-1:0]       l2_neg;
  logic [31:0]         l2_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid <= 1'b0;
    end else if (adv) begin
      l2_valid <= l1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_lim <= l1_big > {17'b0, max_wheel_speed};
      l2_mag <= l1_mag;
      l2_neg <= l1_neg;
      l2_big <= l1_big;
      for (int l = 0; l < WC; l++) begin
        l2_prod[l] <= 47'(l1_mag[l]) * 47'(max_wheel_speed);
      end
    end
  end

  logic                l3_valid;
  logic [WC-1:0][46:0] l3_n;
  logic [31:0]         l3_big;
  logic [Side2W-1:0]   l3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      l3_valid <= 1'b0;
    end else if (adv) begin
      l3_valid <= l2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3_big  <= l2_big;
      l3_side <= {l2_lim, l2_neg, l2_mag};
      for (int l = 0; l < WC; l++) begin
        l3_n[l] <= l2_prod[l] + 47'(l2_big >> 1);
      end
    end
  end

  logic                d2_valid;
  logic [WC-1:0][15:0] d2_q;
  logic [Side2W-1:0]   d2_side;

  omk_div #(
    .LANES(WC),
    .DW(47),
    .VW(32),
    .QW(16),
    .SW(Side2W)
  ) u_div_scale (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(l3_valid),
    .dividend(l3_n),
    .divisor(l3_big),
    .in_side(l3_side),
    .out_valid(d2_valid),
    .quotient(d2_q),
    .out_side(d2_side)
  );

  // Final selection and sign.
  logic                d2_lim;
  logic [WC-1:0]       d2_neg;
  logic [WC-1:0][31:0] d2_mag;
  logic [3:0][15:0]    ws;

  assign {d2_lim, d2_neg, d2_mag} = d2_side;

  always_comb begin
    logic [31:0] v;
    ws = '0;
    for (int l = 0; l < WC; l++) begin
      v = d2_lim ? {16'b0, d2_q[l]} : d2_mag[l];
      ws[l] = d2_neg[l] ? 16'(-v) : v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wheel_speed_a <= ws[0];
      wheel_speed_b <= ws[1];
      wheel_speed_c <= ws[2];
      wheel_speed_d <= ws[3];
      was_limited   <= d2_lim;
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] spin;
    logic [15:0]        head;
  } command_t;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
    logic               lim;
  } wheel_set_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] speed_x = 0, speed_y = 0, spin_rate = 0;
  logic [15:0] heading = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d;
  logic was_limited;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  // Local copy of the register file.
  logic [15:0] mount_angle [4];
  logic [11:0] body_dist;
  logic [11:0] radius;
  logic [14:0] speed_limit;

  command_t   pending_cmds [$];
  wheel_set_t expected_wheels [$];
  int errors = 0;
  bit steady = 0;

  omni_wheel_speed_kinematics u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic void add_cmd(input command_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic longint half_away_div(longint n, longint d);
    if (n < 0) return -(((-n) + d / 2) / d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint q30_round(longint v);
    if (v < 0) return -((-v + 16384) >>> 15);
    return (v + 16384) >>> 15;
  endfunction

  // Q15 cosine and sine of a 16-bit binary angle by a 30-step CORDIC.
  task automatic sin_cos(input logic [15:0] ang, output longint cs, output longint sn);
    logic [31:0] th;
    longint x, y, z, nx, cr, sr;
    th = {ang, 16'h0000};
    x = 652032874;
    y = 0;
    z = longint'(th[29:0]);
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(omk_pkg::CORDIC_ATAN[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(omk_pkg::CORDIC_ATAN[i]);
      end
      x = nx;
    end
    cr = q30_round(x);
    sr = q30_round(y);
    case (th[31:30])
      2'd0: begin cs = cr; sn = sr; end
      2'd1: begin cs = -sr; sn = cr; end
      2'd2: begin cs = -cr; sn = -sr; end
      default: begin cs = sr; sn = -cr; end
    endcase
  endtask

  task automatic predict_wheels(input command_t cmd, output wheel_set_t res);
    longint ch, sh, ca, sa, vxr, vyr, num, den, big, r;
    longint w [4];
    big = 0;
    r = (radius == 0) ? 1 : longint'(radius);
    den = r * 4194304;
    sin_cos(cmd.head, ch, sh);
    vxr = longint'(cmd.vx) * ch + longint'(cmd.vy) * sh;
    vyr = -longint'(cmd.vx) * sh + longint'(cmd.vy) * ch;
    for (int i = 0; i < 4; i++) begin
      sin_cos(mount_angle[i], ca, sa);
      num = (-sa * vxr + ca * vyr) * 10 +
            longint'(cmd.spin) * longint'(body_dist) * 262144;
      w[i] = half_away_div(num, den);
      if (w[i] > big) big = w[i];
      if (-w[i] > big) big = -w[i];
    end
    res.lim = big > longint'(speed_limit);
    if (res.lim)
      for (int i = 0; i < 4; i++) w[i] = half_away_div(w[i] * longint'(speed_limit), big);
    res.a = w[0][15:0];
    res.b = w[1][15:0];
    res.c = w[2][15:0];
    res.d = w[3][15:0];
  endtask

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= 22)) begin
        command_t c;
        c = pending_cmds.pop_front();
        speed_x <= c.vx;
        speed_y <= c.vy;
        spin_rate <= c.spin;
        heading <= c.head;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 22);
  end

  // Monitor: predict at each input transfer, check at each output transfer.
  always @(posedge clk) begin
    wheel_set_t p, got, want;
    if (!rst && in_valid && !in_stall) begin
      predict_wheels({speed_x, speed_y, spin_rate, heading}, p);
      expected_wheels.insert(expected_wheels.size(), p);
    end
    if (!rst && out_valid && !out_stall) begin
      got = {wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d, was_limited};
      if (expected_wheels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_wheels.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      omk_pkg::REG_ANGLE_A, omk_pkg::REG_ANGLE_B, omk_pkg::REG_ANGLE_C,
      omk_pkg::REG_ANGLE_D: mount_angle[idx[1:0]] = val;
      omk_pkg::REG_BODY_DIST: body_dist = val[11:0];
      omk_pkg::REG_RADIUS: radius = val[11:0];
      omk_pkg::REG_MAX_SPEED: speed_limit = val[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] a0, a1, a2, a3, bd, rad, lim);
    write_reg(omk_pkg::REG_ANGLE_A, a0);
    write_reg(omk_pkg::REG_ANGLE_B, a1);
    write_reg(omk_pkg::REG_ANGLE_C, a2);
    write_reg(omk_pkg::REG_ANGLE_D, a3);
    write_reg(omk_pkg::REG_BODY_DIST, bd);
    write_reg(omk_pkg::REG_RADIUS, rad);
    write_reg(omk_pkg::REG_MAX_SPEED, lim);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7) - 4);
      1, 2: return 16'($urandom_range(4000) - 2000);
      3: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      add_cmd({rand_field(), rand_field(), rand_field(), 16'($urandom)});
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_wheels.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    mount_angle = '{16'd6007, 16'd26760, 16'd40960, 16'd57344};
    body_dist = 806;
    radius = 276;
    speed_limit = 28160;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Defaults: directed corners first.
    add_cmd({16'sd0, 16'sd0, 16'sd0, 16'd0});
    add_cmd({16'sd1, 16'sd0, 16'sd0, 16'd0});
    add_cmd({16'sd0, -16'sd1, 16'sd1, 16'd0});
    add_cmd({16'sd32767, 16'sd0, 16'sd0, 16'd0});
    add_cmd({-16'sd32768, 16'sd0, 16'sd0, 16'd16384});
    add_cmd({16'sd0, 16'sd32767, 16'sd0, 16'd32768});
    add_cmd({16'sd0, -16'sd32768, 16'sd0, 16'd49152});
    add_cmd({16'sd0, 16'sd0, 16'sd32767, 16'd65535});
    add_cmd({16'sd0, 16'sd0, -16'sd32768, 16'd1});
    add_cmd({16'sd500, -16'sd700, 16'sd300, 16'd8192});
    add_cmd({-16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF});
    add_cmd({16'sd32767, 16'sd32767, 16'sd32767, 16'h5555});
    queue_random(80);
    drain();

    // Zero radius and zero limit, with an ignored write to the unused index.
    write_all(16'd0, 16'hFFFF, 16'd16384, 16'd49152, 16'hF000, 16'h0000, 16'h8000);
    write_reg(REG_UNUSED, 16'hFFFF);
    add_cmd({16'sd0, 16'sd0, 16'sd0, 16'd0});
    add_cmd({16'sd2, 16'sd0, 16'sd0, 16'd100});
    queue_random(60);
    drain();

    // Widest geometry and highest limit, run without any idling.
    steady = 1;
    write_all(16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'h0FFF, 16'hFFFF, 16'hFFFF);
    queue_random(90);
    drain();
    steady = 0;

    // Smallest wheel, no body distance, limit of one step.
    write_all(16'd1, 16'd21845, 16'd43690, 16'd65534, 16'd0, 16'd1, 16'd1);
    queue_random(60);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(4095, 1)), 16'($urandom_range(32767, 1)));
      queue_random(70);
      drain();
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
